[src/sorted_deadline_timer_queue_top_defines.svh]
// Assertion macros shared by the timer queue modules.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SDTQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define SDTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sdtq_pkg.sv]
package sdtq_pkg;

   localparam int unsigned DELAY_W   = 32;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned OUTCOME_W = 2;
   localparam int unsigned HANDLE_W  = 4;
   localparam int unsigned MAX_FIRE  = 16;
   localparam int unsigned FIRE_CNT_W = 5;

   localparam logic [KIND_W-1:0] KIND_ONCE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   localparam logic [OUTCOME_W-1:0] OUT_STARTED  = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUT_REJECTED = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUT_FULL     = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUT_FIRED    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_FIRE,
      ST_INSERT,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic do_start;
      logic do_tick;
      logic do_pop;
      logic do_insert;
      logic rsp_load;
      logic [OUTCOME_W-1:0] rsp_outcome;
      logic rsp_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_start;
      logic start_bad;
      logic table_full;
      logic head_due;
      logic head_repeat;
      logic rsp_busy;
   } stat_type;

endpackage

[src/sdtq_datapath.sv]
`include "sorted_deadline_timer_queue_top_defines.svh"
module sdtq_datapath
   import sdtq_pkg::*;
#(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned TIME_BITS = 40
) (
   input  logic clock,
   input  logic reset,
   input  logic                req_mode,
   input  logic [DELAY_W-1:0]  req_delay,
   input  logic [KIND_W-1:0]   req_kind,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] dl_ff [DEPTH];
   logic [DELAY_W-1:0]   per_ff [DEPTH];
   logic [IDX_W-1:0]     hdl_ff [DEPTH];
   logic [DEPTH-1:0]     vld_ff;
   logic [DEPTH-1:0]     free_ff;

   logic                 mode_ff;
   logic [DELAY_W-1:0]   delay_ff;
   logic [KIND_W-1:0]    kind_ff;

   // pending insertion operands
   logic [TIME_BITS-1:0] ins_dl_ff;
   logic [DELAY_W-1:0]   ins_per_ff;
   logic [IDX_W-1:0]     ins_h_ff;

   logic                 rv_ff;
   logic [OUTCOME_W-1:0] ro_ff;
   logic [HANDLE_W-1:0]  rh_ff;
   logic                 rl_ff;

   logic [IDX_W-1:0]     low_free;
   logic                 any_free;
   logic [DEPTH-1:0]     after_eq;

   always_comb begin
      low_free = '0;
      any_free = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            low_free = IDX_W'(i);
            any_free = 1'b1;
         end
      end
   end

   // an entry moves down one when the new deadline sorts before it
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         after_eq[i] = vld_ff[i] && (ins_dl_ff < dl_ff[i]);
      end
   end

   assign now_in = now_ff + TIME_BITS'(1);

   assign stat.req_start   = mode_ff;
   assign stat.start_bad   = (delay_ff == '0) ||
                             (kind_ff != KIND_ONCE && kind_ff != KIND_REPEAT);
   assign stat.table_full  = !any_free || vld_ff[DEPTH-1];
   assign stat.head_due    = vld_ff[0] && (dl_ff[0] < now_ff);
   assign stat.head_repeat = per_ff[0] != '0;
   assign stat.rsp_busy    = rv_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff  <= req_mode;
         delay_ff <= req_delay;
         kind_ff  <= req_kind;
      end
      if (cmd.do_start) begin
         ins_dl_ff  <= now_ff + TIME_BITS'(delay_ff);
         ins_per_ff <= (kind_ff == KIND_REPEAT) ? delay_ff : '0;
         ins_h_ff   <= low_free;
      end
      if (cmd.do_pop) begin
         ins_dl_ff  <= dl_ff[0] + TIME_BITS'(per_ff[0]);
         ins_per_ff <= per_ff[0];
         ins_h_ff   <= hdl_ff[0];
         for (int i = 0; i + 1 < DEPTH; i++) begin
            dl_ff[i]  <= dl_ff[i+1];
            per_ff[i] <= per_ff[i+1];
            hdl_ff[i] <= hdl_ff[i+1];
         end
      end
      if (cmd.do_insert) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (after_eq[i]) begin
               if (i + 1 < DEPTH) begin
                  dl_ff[(i+1) % DEPTH]  <= dl_ff[i];
                  per_ff[(i+1) % DEPTH] <= per_ff[i];
                  hdl_ff[(i+1) % DEPTH] <= hdl_ff[i];
               end
            end
         end
         for (int i = 0; i < DEPTH; i++) begin
            // slot i receives the new entry when it is the first moved or first empty
            if ((after_eq[i] || !vld_ff[i]) &&
                (i == 0 || (!after_eq[(i == 0) ? 0 : i-1] && vld_ff[(i == 0) ? 0 : i-1]))) begin
               dl_ff[i]  <= ins_dl_ff;
               per_ff[i] <= ins_per_ff;
               hdl_ff[i] <= ins_h_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff  <= '0;
         vld_ff  <= '0;
         free_ff <= '1;
         rv_ff   <= 1'b0;
      end else begin
         if (cmd.do_tick) begin
            now_ff <= now_in;
         end
         if (cmd.do_start) begin
            free_ff[low_free] <= 1'b0;
         end
         if (cmd.do_pop) begin
            vld_ff <= vld_ff >> 1;
            if (per_ff[0] == '0) begin
               free_ff[hdl_ff[0]] <= 1'b1;
            end
         end
         if (cmd.do_insert) begin
            vld_ff <= {vld_ff[DEPTH-2:0], 1'b1};
         end
         if (cmd.rsp_load) begin
            rv_ff <= 1'b1;
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   // ins_h_ff holds the handle of the started timer or of the timer just popped
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         ro_ff <= cmd.rsp_outcome;
         rh_ff <= (cmd.rsp_outcome == OUT_STARTED || cmd.rsp_outcome == OUT_FIRED) ?
                  HANDLE_W'(ins_h_ff) : '0;
         rl_ff <= cmd.rsp_last;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {2'b00, rh_ff, ro_ff};
   assign rsp_tlast  = rl_ff;

   `SDTQ_ASSERT_IMP(a_ins_room, clock, reset, cmd.do_insert, !vld_ff[DEPTH-1],
      "insert into a full table")
   `SDTQ_ASSERT_IMP(a_pop_valid, clock, reset, cmd.do_pop, vld_ff[0],
      "pop from an empty table")
   `SDTQ_ASSERT_IMP(a_rsp_hold, clock, reset, cmd.rsp_load, !rv_ff || rsp_tready,
      "result overwritten before taken")
endmodule

[src/sdtq_ctrl.sv]
`include "sorted_deadline_timer_queue_top_defines.svh"
module sdtq_ctrl
   import sdtq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;
   logic [FIRE_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_free;

   assign rsp_free = !stat.rsp_busy || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_START;
               cnt_in   = '0;
            end
         end
         ST_START: begin
            if (!stat.req_start) begin
               state_in = ST_CHECK;
            end else if (rsp_free) begin
               state_in = (stat.start_bad || stat.table_full) ? ST_IDLE : ST_INSERT;
            end
         end
         ST_CHECK: begin
            if (stat.head_due && cnt_ff != FIRE_CNT_W'(MAX_FIRE)) begin
               state_in = ST_FIRE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FIRE: begin
            state_in = stat.head_repeat ? ST_INSERT : ST_RESP;
         end
         ST_INSERT: begin
            state_in = stat.req_start ? ST_IDLE : ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_CHECK;
               cnt_in   = cnt_ff + FIRE_CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_START: begin
            if (!stat.req_start) begin
               cmd.do_tick = 1'b1;
            end else if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_last = 1'b1;
               if (stat.start_bad) begin
                  cmd.rsp_outcome = OUT_REJECTED;
               end else if (stat.table_full) begin
                  cmd.rsp_outcome = OUT_FULL;
               end else begin
                  cmd.rsp_load = 1'b0;
                  cmd.do_start = 1'b1;
               end
            end
         end
         ST_FIRE: cmd.do_pop = 1'b1;
         ST_INSERT: begin
            cmd.do_insert = 1'b1;
            if (stat.req_start) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_outcome = OUT_STARTED;
               cmd.rsp_last    = 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_outcome = OUT_FIRED;
               cmd.rsp_last    = !stat.head_due || cnt_ff == FIRE_CNT_W'(MAX_FIRE - 1);
            end
         end
         default: ;
      endcase
   end

   `SDTQ_ASSERT_IMP(a_cnt_cap, clock, reset, state_ff == ST_FIRE,
      cnt_ff < FIRE_CNT_W'(MAX_FIRE), "too many timers fired on one tick")
   `SDTQ_ASSERT_NEXT(a_accept_go, clock, reset, req_tvalid && req_tready,
      state_ff == ST_START, "accepted request not started")
   `SDTQ_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE,
      "ready outside idle")
endmodule

[src/sorted_deadline_timer_queue_top.sv]
// Channel   Dir  Ports                          Contents
// request   in   req_tvalid/tready/tdata/tuser  tuser: mode; tdata: delay_ms, timer_kind
// result    out  rsp_tvalid/tready/tdata/tlast  tdata: outcome, handle; tlast: last
// A refused start passes idle and the start state; an accepted one also passes the insert
// state. A tick passes idle, start and check, then per fired timer fire and result, with
// insert between them for a repeat timer. The single shared table shift register does one
// pop or one insertion per cycle while no stalled result holds the controller. Reset is
// synchronous and empties the table at once. A stalled result holds the controller until it is taken.
module sorted_deadline_timer_queue_top
   import sdtq_pkg::*;
#(
   parameter int unsigned DEPTH     = 16,
   parameter int unsigned TIME_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // delay_ms, timer_kind, zero fill
   input  logic        req_tuser,  // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // outcome, handle, zero fill
   output logic        rsp_tlast
);
   cmd_type  cmd;
   stat_type stat;

   sdtq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tready(rsp_tready), .stat(stat), .cmd(cmd)
   );

   sdtq_datapath #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .reset(reset),
      .req_mode(req_tuser), .req_delay(req_tdata[31:0]), .req_kind(req_tdata[33:32]),
      .cmd(cmd), .stat(stat),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule
